// ----- rtl/core/bdpp_pkg.sv -----
// package for the backdoor pointer port: codes, constants, shared types
// no dependencies
`default_nettype none
package bdpp_pkg;
    localparam logic [31:0] MAGIC_VALUE   = 32'h564D5868;
    localparam logic [31:0] SUB_ENABLE    = 32'h45414552;
    localparam logic [31:0] SUB_RELATIVE  = 32'h000000F5;
    localparam logic [31:0] SUB_ABSOLUTE  = 32'h53424152;
    localparam logic [15:0] CMD_VERSION   = 16'd10;
    localparam logic [15:0] CMD_DATA      = 16'd39;
    localparam logic [15:0] CMD_STATUS    = 16'd40;
    localparam logic [15:0] CMD_POINTER   = 16'd41;
    localparam logic [15:0] CENTER        = 16'h7fff;
    localparam logic [31:0] STATUS_UPDATED = 32'd4;
    localparam int          QUO_BITS      = 33;
    localparam int          NUM_BITS      = 33;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_MOVE   = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;
    localparam logic [1:0] KIND_WHEEL  = 2'd3;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_OFFSET_X = 2'd2;
    localparam logic [1:0] REG_OFFSET_Y = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, do immediate work
        logic div_start; // start division for the selected axis
        logic axis_y;    // 0 x axis, 1 y axis
        logic commit;    // apply move result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_move;
        logic div_done;
    } t_stat;
endpackage
`default_nettype wire

// ----- rtl/core/bdpp_div.sv -----
// restoring divider, one quotient bit a cycle
// depends on bdpp_pkg
`default_nettype none
module bdpp_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [bdpp_pkg::NUM_BITS-1:0]  i_num,
    input  wire logic [bdpp_pkg::NUM_BITS-1:0]  i_den,
    output      logic                           o_done,
    output      logic [bdpp_pkg::QUO_BITS-1:0]  o_quo
);
    import bdpp_pkg::*;
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_rem, r_quo, r_den;
    logic [CW-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [NUM_BITS:0]   w_trial;

    // shift in next numerator bit and try subtract
    assign w_trial = {r_rem, r_quo[NUM_BITS-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[NUM_BITS]) begin
                r_rem <= w_trial[NUM_BITS-1:0];
                r_quo <= {r_quo[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[NUM_BITS-2:0], r_quo[NUM_BITS-1]};
                r_quo <= {r_quo[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_done) else $error("divider done while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider count ran out");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/bdpp_ctrl.sv -----
// controller: sequences a request through capture, two divisions for a move, and output
// depends on bdpp_pkg
`default_nettype none
module bdpp_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output      logic            o_in_stall,
    input  wire logic            i_out_free,
    output      logic            o_out_load,
    output      bdpp_pkg::t_cmd  o_cmd,
    input  wire bdpp_pkg::t_stat i_stat
);
    import bdpp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DECD  = 6'b000010,
        S_DIVX  = 6'b000100,
        S_DIVY  = 6'b001000,
        S_DONE  = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_out_load   = 1'b0;
        o_in_stall   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECD;
                end
            end
            S_DECD: begin
                if (i_stat.is_move) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVX;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_DIVX: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.axis_y    = 1'b1;
                    n_state         = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.axis_y = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

`ifndef SYNTH
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_commit_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> $past(r_state) == S_DIVY) else $error("commit out of order");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/bdpp_dp.sv -----
// datapath: pointer state, config registers, result formation
// depends on bdpp_pkg, bdpp_div
`default_nettype none
module bdpp_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic [1:0]      i_kind,
    input  wire logic [31:0]     i_magic_word,
    input  wire logic [15:0]     i_command,
    input  wire logic [31:0]     i_sub_command,
    input  wire logic [15:0]     i_abs_x,
    input  wire logic [15:0]     i_abs_y,
    input  wire logic            i_button_left,
    input  wire logic            i_button_right,
    input  wire logic            i_button_middle,
    input  wire logic [15:0]     i_wheel_delta,
    input  wire bdpp_pkg::t_cmd  i_cmd,
    output      bdpp_pkg::t_stat o_stat,
    output      logic [31:0]     o_ret_a,
    output      logic [31:0]     o_ret_b,
    output      logic [15:0]     o_ret_c,
    output      logic [7:0]      o_ret_d,
    output      logic [3:0]      o_write_mask,
    output      logic            o_changed
);
    import bdpp_pkg::*;

    logic [15:0] r_width, r_height, r_off_x, r_off_y;
    logic        r_active, r_pending;
    logic [7:0]  r_buttons, r_wheel;
    logic [15:0] r_pos_x, r_pos_y, r_new_x;
    logic [15:0] r_pos_y_n;
    logic [15:0] r_abs_x, r_abs_y;
    logic        r_move;
    logic [31:0] r_a, r_b;
    logic [15:0] r_c;
    logic [7:0]  r_d;
    logic [3:0]  r_mask;
    logic        r_chg;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 16'd640;
            r_height <= 16'd480;
            r_off_x  <= '0;
            r_off_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:    r_width  <= i_cfg_data;
                REG_HEIGHT:   r_height <= i_cfg_data;
                REG_OFFSET_X: r_off_x  <= i_cfg_data;
                REG_OFFSET_Y: r_off_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp and numerator/divisor for the selected axis
    logic [15:0] w_abs, w_off, w_res, w_pos, w_div;
    logic [16:0] w_p;
    logic [NUM_BITS-1:0] w_num, w_den;
    logic [QUO_BITS-1:0] w_quo;
    logic        w_done;
    logic [15:0] w_q16;

    always_comb begin
        w_abs = i_cmd.axis_y ? r_abs_y  : r_abs_x;
        w_off = i_cmd.axis_y ? r_off_y  : r_off_x;
        w_res = i_cmd.axis_y ? r_height : r_width;
        w_pos = (w_abs > w_off) ? (w_abs - w_off) : 16'd0;
        if (w_pos > w_res) w_pos = w_res;
        w_div = (w_res > 16'd1) ? (w_res - 16'd1) : 16'd1;
        // 2*pos*65535 = (pos<<17) - (pos<<1)
        w_p   = {w_pos, 1'b0};
        w_num = ({w_p, 16'd0} - {16'd0, w_p}) + {16'd0, 1'b0, w_div};
        w_den = {16'd0, w_div, 1'b0};
    end

    bdpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_q16 = (w_quo > QUO_BITS'(16'hFFFF)) ? 16'hFFFF : w_quo[15:0];
    assign o_stat.is_move  = r_move;
    assign o_stat.div_done = w_done;

    // immediate event work
    logic [7:0]  w_nb;
    logic signed [16:0] w_sum;
    logic [7:0]  w_nw;
    always_comb begin
        w_nb  = {2'b00, i_button_left, i_button_right, i_button_middle, 3'b000};
        w_sum = 17'(signed'(i_wheel_delta)) + 17'(signed'(r_wheel));
        if (w_sum > 17'sd127)       w_nw = 8'h7f;
        else if (w_sum < -17'sd128) w_nw = 8'h80;
        else                        w_nw = w_sum[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_pending <= 1'b0;
            r_buttons <= '0;
            r_wheel   <= '0;
            r_pos_x   <= CENTER;
            r_pos_y   <= CENTER;
            r_move    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_a    <= '0;
                r_b    <= '0;
                r_c    <= '0;
                r_d    <= '0;
                r_mask <= '0;
                r_chg  <= 1'b0;
                r_move <= 1'b0;
                r_abs_x <= i_abs_x;
                r_abs_y <= i_abs_y;
                if (i_kind == KIND_READ) begin
                    r_mask <= 4'd1;
                    if (i_magic_word == MAGIC_VALUE) begin
                        r_a <= i_magic_word;
                        case (i_command)
                            CMD_VERSION: begin
                                r_a    <= '0;
                                r_b    <= MAGIC_VALUE;
                                r_mask <= 4'd3;
                            end
                            CMD_DATA: begin
                                r_a     <= {24'd0, r_buttons};
                                r_b     <= {16'd0, r_pos_x};
                                r_c     <= r_pos_y;
                                r_d     <= r_wheel;
                                r_mask  <= 4'd15;
                                r_wheel <= '0;
                            end
                            CMD_STATUS: begin
                                r_a       <= r_pending ? STATUS_UPDATED : 32'd0;
                                r_pending <= 1'b0;
                            end
                            CMD_POINTER: begin
                                if (i_sub_command == SUB_RELATIVE ||
                                    i_sub_command == SUB_ABSOLUTE) begin
                                    r_active  <= (i_sub_command == SUB_ABSOLUTE);
                                    r_buttons <= '0;
                                    r_wheel   <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end else if (r_active) begin
                    case (i_kind)
                        KIND_MOVE: r_move <= 1'b1;
                        KIND_BUTTON: begin
                            r_buttons <= w_nb;
                            if (w_nb != r_buttons) begin
                                r_chg     <= 1'b1;
                                r_pending <= 1'b1;
                            end
                        end
                        KIND_WHEEL: begin
                            r_wheel <= w_nw;
                            if (w_nw != r_wheel) begin
                                r_chg     <= 1'b1;
                                r_pending <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // hold x quotient until y finishes; x ends as the y division starts
            if (w_done && i_cmd.div_start) r_new_x <= w_q16;
            if (i_cmd.commit) begin
                r_pos_x <= r_new_x;
                r_pos_y <= r_pos_y_n;
                if (r_new_x != r_pos_x || r_pos_y_n != r_pos_y) begin
                    r_chg     <= 1'b1;
                    r_pending <= 1'b1;
                end
            end
        end
    end

    // y quotient captured when its division ends
    always_ff @(posedge i_clk) begin
        if (w_done && i_cmd.axis_y && !i_cmd.div_start) r_pos_y_n <= w_q16;
    end

    assign o_ret_a      = r_a;
    assign o_ret_b      = r_b;
    assign o_ret_c      = r_c;
    assign o_ret_d      = r_d;
    assign o_write_mask = r_mask;
    assign o_changed    = r_chg;

`ifndef SYNTH
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_quo <= QUO_BITS'(17'h1FFFF)) else $error("quotient too wide");
    a_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !r_active && i_kind != KIND_READ) |=> !r_chg)
        else $error("inactive event changed state");
    a_chg_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_chg) |-> r_pending) else $error("change without pending flag");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/backdoor_pointer_port.sv -----
// backdoor pointer port top level
// reads and button/wheel events skip the divider; a move runs
//   two 33-step divisions in series in one shared divider; one request at a time
// a new request is accepted only once the previous result is in the output register; it frees on take
// reset: synchronous active low, clears state and loads default resolution
// depends on bdpp_pkg, bdpp_ctrl, bdpp_dp, bdpp_div
`default_nettype none
module backdoor_pointer_port (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_magic_word,
    input  wire logic [15:0] i_command,
    input  wire logic [31:0] i_sub_command,
    input  wire logic [15:0] i_abs_x,
    input  wire logic [15:0] i_abs_y,
    input  wire logic        i_button_left,
    input  wire logic        i_button_right,
    input  wire logic        i_button_middle,
    input  wire logic [15:0] i_wheel_delta,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [31:0] o_ret_a,
    output      logic [31:0] o_ret_b,
    output      logic [15:0] o_ret_c,
    output      logic [7:0]  o_ret_d,
    output      logic [3:0]  o_write_mask,
    output      logic        o_changed
);
    import bdpp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_load, w_free;
    logic [31:0] w_a, w_b;
    logic [15:0] w_c;
    logic [7:0]  w_d;
    logic [3:0]  w_m;
    logic        w_ch;
    logic        r_ov;

    assign w_free = !r_ov || !i_out_stall;

    bdpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (w_free),
        .o_out_load (w_load),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    bdpp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_magic_word    (i_magic_word),
        .i_command       (i_command),
        .i_sub_command   (i_sub_command),
        .i_abs_x         (i_abs_x),
        .i_abs_y         (i_abs_y),
        .i_button_left   (i_button_left),
        .i_button_right  (i_button_right),
        .i_button_middle (i_button_middle),
        .i_wheel_delta   (i_wheel_delta),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_ret_a         (w_a),
        .o_ret_b         (w_b),
        .o_ret_c         (w_c),
        .o_ret_d         (w_d),
        .o_write_mask    (w_m),
        .o_changed       (w_ch)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_ret_a      <= w_a;
            o_ret_b      <= w_b;
            o_ret_c      <= w_c;
            o_ret_d      <= w_d;
            o_write_mask <= w_m;
            o_changed    <= w_ch;
        end
    end

    assign o_out_valid = r_ov;

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_ret_a))
        else $error("stalled result changed");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_free) else $error("result overwritten");
    a_read_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_mask != 4'd0) |-> o_write_mask[0])
        else $error("read result missing accumulator");
`endif
endmodule
`default_nettype wire
